/* rtl/core/ras_pkg.sv */
// ----------------------------------------------------------------------------
// ras_pkg: shared types and constants of the ratiometric sampler
// Widths, reset codes, register indexes and divider handshake structs.
// ----------------------------------------------------------------------------
package ras_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CODE_W-1:0] SIGNAL_CODE_RESET = 5'b00011;
    localparam logic [CODE_W-1:0] REF_CODE_RESET    = 5'b11111;
    localparam logic [WORD_W-1:0] DIVISOR_ONE       = 16'h0001;
    localparam logic [WORD_W-1:0] RATIO_MAX         = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_CODE    = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic  start;
        t_word numer;
        t_word denom;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

endpackage

/* rtl/core/ratiometric_adc_sampler.sv */
// ----------------------------------------------------------------------------
// ratiometric_adc_sampler: signal/reference sampler with ratio readout
// Files converter samples under the selected channel, toggles the channel
// and returns the saturated unsigned 0.16 ratio of signal to reference on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries i_mode and i_sample. Mode 0 files
//   the sample and flips the channel; mode 1 requests the ratio.
//   Output channel (o_valid/i_ready) carries o_ratio and o_channel_select,
//   one item per input item, held in an output register until taken.
//   Timing: a sample item shows its result in the cycle after acceptance. A
//   read item runs through the bit-serial divider, one quotient bit per cycle
//   unless the ratio saturates, then through its done and output registers.
//   One item is in work at a time: o_ready is low during a divide and while
//   the output register holds an item that the receiver has not taken.
//   A stalled receiver therefore stalls the input side.
//   Reset clears the stored samples, selects the signal channel and loads
//   codes 3 (signal) and 31 (reference). Config writes through i_cfg_we take
//   effect on the next sample item and do not change the selected channel.
// ----------------------------------------------------------------------------
module ratiometric_adc_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ras_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ras_pkg::CODE_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [ras_pkg::WORD_W-1:0]    i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ras_pkg::WORD_W-1:0]    o_ratio,
    output logic [ras_pkg::CODE_W-1:0]    o_channel_select
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic           r_state;
    ras_pkg::t_code r_sig_code;
    ras_pkg::t_code r_ref_code;
    ras_pkg::t_code r_chan;
    ras_pkg::t_word r_sig_val;
    ras_pkg::t_word r_ref_val;
    logic           r_out_valid;
    ras_pkg::t_word r_out_ratio;

    logic              accept;
    logic              out_load;
    ras_pkg::t_div_req div_req;
    ras_pkg::t_div_rsp div_rsp;

    assign o_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == ST_IDLE) ? (accept && !i_mode) : div_rsp.done;

    assign div_req.start = accept && i_mode;
    assign div_req.numer = r_sig_val;
    assign div_req.denom = (r_ref_val != '0) ? r_ref_val : ras_pkg::DIVISOR_ONE;

    ras_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_code <= ras_pkg::SIGNAL_CODE_RESET;
            r_ref_code <= ras_pkg::REF_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ras_pkg::CFG_SIGNAL_CODE: r_sig_code <= i_cfg_data;
                ras_pkg::CFG_REF_CODE:    r_ref_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_chan      <= ras_pkg::SIGNAL_CODE_RESET;
            r_sig_val   <= '0;
            r_ref_val   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_mode) begin
                            r_state <= ST_DIV;
                        end else begin
                            if (r_chan == r_ref_code) begin
                                r_ref_val <= i_sample;
                                r_chan    <= r_sig_code;
                            end else begin
                                r_sig_val <= i_sample;
                                r_chan    <= r_ref_code;
                            end
                            r_out_ratio <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_out_ratio <= div_rsp.quotient;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ratio          = r_out_ratio;
    assign o_channel_select = r_chan;

endmodule

/* rtl/core/ras_div.sv */
// ----------------------------------------------------------------------------
// ras_div: bit-serial saturating divider
// Computes (numer << 16) / denom, saturated to 16 bits, one quotient bit
// per cycle with a shared compare-and-subtract unit. Denom must be nonzero.
// ----------------------------------------------------------------------------
module ras_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ras_pkg::t_div_req i_req,
    output ras_pkg::t_div_rsp o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [ras_pkg::CNT_W-1:0]  r_cnt;
    logic [ras_pkg::WORD_W:0]   r_rem;
    logic [ras_pkg::WORD_W-1:0] r_den;
    logic [ras_pkg::WORD_W-1:0] r_quo;

    logic [ras_pkg::WORD_W:0]   rem_shift;
    logic                       take;
    logic                       saturate;

    assign rem_shift = {r_rem[ras_pkg::WORD_W-1:0], 1'b0};
    assign take      = rem_shift >= {1'b0, r_den};
    assign saturate  = i_req.numer >= i_req.denom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= (i_req.start && !r_busy && saturate) ||
                      (r_busy && (r_cnt == ras_pkg::CNT_W'(1)));
            if (i_req.start && !r_busy) begin
                r_den <= i_req.denom;
                r_rem <= {1'b0, i_req.numer};
                if (saturate) begin
                    r_quo  <= ras_pkg::RATIO_MAX;
                end else begin
                    r_quo  <= '0;
                    r_busy <= 1'b1;
                    r_cnt  <= ras_pkg::CNT_W'(ras_pkg::DIV_STEPS);
                end
            end else if (r_busy) begin
                r_rem <= take ? (rem_shift - {1'b0, r_den}) : rem_shift;
                r_quo <= {r_quo[ras_pkg::WORD_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ras_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ratiometric sampler
// Drives conversion and read items over the valid/ready input, mirrors the
// channel toggling, sample filing and saturated ratio divide in a local
// model, and compares every readout field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import ras_pkg::*;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;

    typedef struct packed {
        logic  mode;
        t_word sample;
    } t_conv_item;

    typedef struct packed {
        t_word ratio;
        t_code chan;
    } t_readout;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SIGNAL_CODE;
    t_code                i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 i_mode      = MODE_SAMPLE;
    t_word                i_sample    = '0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    t_word                o_ratio;
    t_code                o_channel_select;

    t_conv_item items_to_send[$];
    t_readout   readouts_due[$];

    t_word mdl_signal;
    t_word mdl_reference;
    t_code mdl_channel;
    t_code mdl_sig_code;
    t_code mdl_ref_code;

    logic        calm        = 1'b0;
    logic        hold_armed  = 1'b0;
    int unsigned accepted    = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    ratiometric_adc_sampler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ratio          (o_ratio),
        .o_channel_select (o_channel_select)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_word saturated_ratio(input t_word sig, input t_word refv);
        logic [31:0] numer;
        logic [31:0] denom;
        logic [31:0] quot;
        numer = {sig, 16'h0000};
        denom = (refv == '0) ? 32'd1 : {16'h0000, refv};
        quot  = numer / denom;
        return (quot > 32'h0000_FFFF) ? RATIO_MAX : quot[WORD_W-1:0];
    endfunction

    function automatic void file_or_read(input logic mode, input t_word sample);
        t_readout r;
        r.ratio = '0;
        if (mode == MODE_SAMPLE) begin
            if (mdl_channel == mdl_ref_code) begin
                mdl_reference = sample;
                mdl_channel   = mdl_sig_code;
            end else begin
                mdl_signal  = sample;
                mdl_channel = mdl_ref_code;
            end
        end else begin
            r.ratio = saturated_ratio(mdl_signal, mdl_reference);
        end
        r.chan = mdl_channel;
        readouts_due.push_back(r);
    endfunction

    function automatic t_word pick_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return t_word'($urandom_range(0, 255));
            3: return t_word'($urandom_range(16'hF000, 16'hFFFF));
            default: return t_word'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_item(input logic mode, input t_word sample);
        t_conv_item it;
        it.mode   = mode;
        it.sample = sample;
        items_to_send.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_code val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SIGNAL_CODE) begin
            mdl_sig_code = val;
        end else begin
            mdl_ref_code = val;
        end
    endtask

    task automatic drain();
        while (items_to_send.size() != 0 || i_valid || readouts_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (24) @(posedge i_clk);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_item(logic'($urandom_range(0, 1)), t_word'($urandom));
                n++;
            end else begin
                queue_item(MODE_SAMPLE, pick_sample());
                queue_item(MODE_SAMPLE, pick_sample());
                queue_item(MODE_READ, t_word'($urandom));
                n += 3;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        logic        v_next;
        int unsigned send_gap;
        t_conv_item  nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            v_next = i_valid;
            if (i_valid && o_ready) begin
                file_or_read(i_mode, i_sample);
                accepted <= accepted + 1;
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (items_to_send.size() != 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 16);
                    end else begin
                        nxt = items_to_send.pop_front();
                        i_mode   <= nxt.mode;
                        i_sample <= nxt.sample;
                        v_next = 1'b1;
                    end
                end
            end
            i_valid <= v_next;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        int unsigned stall;
        int unsigned long_hold;
        logic        hold_done;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall     = 0;
            long_hold = 0;
            hold_done = 1'b0;
        end else begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                long_hold = LONG_HOLD;
            end
            if (long_hold > 0) begin
                long_hold--;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 16);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_readout want;
        if (i_rst_n && o_valid && i_ready) begin
            if (readouts_due.size() == 0) begin
                $error("unexpected item: ratio %0d, channel_select %0d",
                       o_ratio, o_channel_select);
                mismatches++;
            end else begin
                want = readouts_due.pop_front();
                if (o_ratio !== want.ratio) begin
                    $error("ratio: expected %0d, actual %0d", want.ratio, o_ratio);
                    mismatches++;
                end
                if (o_channel_select !== want.chan) begin
                    $error("channel_select: expected %0d, actual %0d",
                           want.chan, o_channel_select);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        mdl_signal    = '0;
        mdl_reference = '0;
        mdl_channel   = SIGNAL_CODE_RESET;
        mdl_sig_code  = SIGNAL_CODE_RESET;
        mdl_ref_code  = REF_CODE_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero signal over zero reference, then zero reference, saturation,
        // half scale and full scale ratios; ends with the signal code selected
        queue_item(MODE_READ, 16'hFFFF);
        queue_item(MODE_SAMPLE, 16'h8000);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'hFFFF);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'hFFFF);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'h0001);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'h0000);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'h1234);
        queue_item(MODE_READ, 16'h0000);
        drain();

        // selected channel no longer matches either code
        write_reg(CFG_SIGNAL_CODE, 5'd7);
        queue_item(MODE_READ, 16'h0000);
        queue_item(MODE_SAMPLE, 16'h00FF);
        queue_item(MODE_SAMPLE, 16'h7FFF);
        queue_item(MODE_READ, 16'h0000);
        drain();

        // both codes equal
        write_reg(CFG_REF_CODE, 5'd0);
        write_reg(CFG_SIGNAL_CODE, 5'd31);
        write_reg(CFG_REF_CODE, 5'd31);
        queue_item(MODE_SAMPLE, 16'h4000);
        queue_item(MODE_SAMPLE, 16'hC000);
        queue_item(MODE_SAMPLE, 16'h2000);
        queue_item(MODE_READ, 16'h0000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_SIGNAL_CODE, 5'd0);
                    write_reg(CFG_REF_CODE, 5'd31);
                end
                1: begin
                    write_reg(CFG_SIGNAL_CODE, 5'd31);
                    write_reg(CFG_REF_CODE, 5'd0);
                end
                2: begin
                    write_reg(CFG_SIGNAL_CODE, SIGNAL_CODE_RESET);
                    write_reg(CFG_REF_CODE, REF_CODE_RESET);
                end
                default: begin
                    write_reg(CFG_SIGNAL_CODE, t_code'($urandom_range(0, 31)));
                    write_reg(CFG_REF_CODE, t_code'($urandom_range(0, 31)));
                end
            endcase
            if (ph == 1) begin
                hold_armed <= 1'b1;
            end
            if (ph == 5) begin
                calm <= 1'b1;
            end
            queue_random(100);
            drain();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ras_pkg.sv
rtl/core/ras_div.sv
rtl/core/ratiometric_adc_sampler.sv
sim/tb_top.sv
